### sv/ksct_pkg.sv
// Package for the keyed stock count table: field widths, codes and item types.
// Used by every module of the block; depends on nothing.
package ksct_pkg;

    localparam int MODE_W        = 2;
    localparam int KEY_FIELD_W   = 64;
    localparam int QTY_W         = 24;
    localparam int STATUS_W      = 3;
    localparam int AISLE_W       = 2;
    localparam int SHELF_W       = 4;
    localparam int COUNT_FIELD_W = 24;

    localparam logic [MODE_W-1:0] MODE_STOCK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WITHDRAW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADQ     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INSUFF   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVER     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd7;

    // Operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_STOCK    = 3'd0,
        OP_WITHDRAW = 3'd1,
        OP_LIST     = 3'd2,
        OP_BADQ     = 3'd3,
        OP_NOKEY    = 3'd4
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [KEY_FIELD_W-1:0] product_key;
        logic [QTY_W-1:0]       quantity;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [AISLE_W-1:0]       aisle;
        logic [SHELF_W-1:0]       shelf;
        logic [KEY_FIELD_W-1:0]   entry_key;
        logic [COUNT_FIELD_W-1:0] entry_count;
        logic                     last;
    } rsp_item_t;

    typedef struct packed {
        op_t                    op;
        logic [KEY_FIELD_W-1:0] key;
        logic [QTY_W-1:0]       qty;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

endpackage

### sv/ksct_front.sv
// Front end: takes request items, masks the key and sorts them into operations.
// Depends on ksct_pkg.
module ksct_front #(
    parameter int KEY_BITS = 64
) (
    input  logic                   cmd_valid,
    input  ksct_pkg::cmd_item_t    cmd,
    output logic                   cmd_stall,
    input  logic                   queue_full,
    output logic                   push,
    output ksct_pkg::queue_entry_t push_entry
);

    localparam logic [ksct_pkg::KEY_FIELD_W-1:0] KEY_MASK =
        ksct_pkg::KEY_FIELD_W'({KEY_BITS{1'b1}});

    logic [ksct_pkg::KEY_FIELD_W-1:0] key_m;
    logic                             known;

    assign key_m     = cmd.product_key & KEY_MASK;
    assign cmd_stall = queue_full;

    always_comb
    begin
        known          = 1'b1;
        push_entry.key = key_m;
        push_entry.qty = cmd.quantity;
        push_entry.op  = ksct_pkg::OP_LIST;
        unique case (cmd.mode)
            ksct_pkg::MODE_STOCK:
            begin
                if (cmd.quantity == '0)
                    push_entry.op = ksct_pkg::OP_BADQ;
                else if (key_m == '0)
                    push_entry.op = ksct_pkg::OP_NOKEY;
                else
                    push_entry.op = ksct_pkg::OP_STOCK;
            end
            ksct_pkg::MODE_WITHDRAW:
            begin
                // a zero key never matches a stored slot
                if (key_m == '0)
                    push_entry.op = ksct_pkg::OP_NOKEY;
                else
                    push_entry.op = ksct_pkg::OP_WITHDRAW;
            end
            ksct_pkg::MODE_LIST:
                push_entry.op = ksct_pkg::OP_LIST;
            default:
                known = 1'b0;   // unused mode: taken and dropped
        endcase
    end

    assign push = cmd_valid && !queue_full && known;

endmodule

### sv/ksct_cmd_fifo.sv
// Two-entry operation queue between the front end and the table engine.
// Depends on ksct_pkg.
module ksct_cmd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ksct_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output ksct_pkg::queue_head_t  head
);

    ksct_pkg::queue_entry_t slot_reg [2];
    logic [1:0]             count_reg, count_next;
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic                   do_pop;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### sv/ksct_back.sv
// Table engine: scans the slot store one slot a cycle while no stalled result
// holds a list scan, updates it and drives the result register. Depends on ksct_pkg.
module ksct_back #(
    parameter int AISLES            = 4,
    parameter int SHELVES_PER_AISLE = 16,
    parameter int KEY_BITS          = 64,
    parameter int COUNT_BITS        = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ksct_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ksct_pkg::rsp_item_t   rsp
);

    localparam int DEPTH = AISLES * SHELVES_PER_AISLE;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = ((COUNT_BITS > ksct_pkg::QTY_W) ? COUNT_BITS : ksct_pkg::QTY_W) + 1;
    localparam logic [SUM_W-1:0] CMAX = SUM_W'({COUNT_BITS{1'b1}});
    localparam logic [ksct_pkg::SHELF_W-1:0] SHELF_LAST =
        ksct_pkg::SHELF_W'(SHELVES_PER_AISLE - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    ksct_pkg::op_t              op_reg, op_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [ksct_pkg::QTY_W-1:0] qty_reg, qty_next;

    // issue stage
    logic [IDX_W:0]                 a_idx_reg, a_idx_next;
    logic [ksct_pkg::AISLE_W-1:0]   a_aisle_reg, a_aisle_next;
    logic [ksct_pkg::SHELF_W-1:0]   a_shelf_reg, a_shelf_next;
    // read-data stage
    logic                           b_valid_reg, b_valid_next;
    logic                           b_occ_reg, b_occ_next;
    logic [IDX_W-1:0]               b_idx_reg, b_idx_next;
    logic [ksct_pkg::AISLE_W-1:0]   b_aisle_reg, b_aisle_next;
    logic [ksct_pkg::SHELF_W-1:0]   b_shelf_reg, b_shelf_next;
    logic [KEY_BITS-1:0]            rd_key_reg;
    logic [COUNT_BITS-1:0]          rd_count_reg;

    logic                           match_reg, match_next;
    logic [IDX_W-1:0]               m_idx_reg, m_idx_next;
    logic [ksct_pkg::AISLE_W-1:0]   m_aisle_reg, m_aisle_next;
    logic [ksct_pkg::SHELF_W-1:0]   m_shelf_reg, m_shelf_next;
    logic [COUNT_BITS-1:0]          m_count_reg, m_count_next;

    logic                           free_reg, free_next;
    logic [IDX_W-1:0]               f_idx_reg, f_idx_next;
    logic [ksct_pkg::AISLE_W-1:0]   f_aisle_reg, f_aisle_next;
    logic [ksct_pkg::SHELF_W-1:0]   f_shelf_reg, f_shelf_next;

    // listed slot held back until the next one shows whether it is the final one
    logic                           pend_reg, pend_next;
    logic [ksct_pkg::AISLE_W-1:0]   p_aisle_reg, p_aisle_next;
    logic [ksct_pkg::SHELF_W-1:0]   p_shelf_reg, p_shelf_next;
    logic [KEY_BITS-1:0]            p_key_reg, p_key_next;
    logic [COUNT_BITS-1:0]          p_count_reg, p_count_next;

    logic [DEPTH-1:0]               occ_reg, occ_next;

    logic                           out_valid_reg, out_valid_next;
    ksct_pkg::rsp_item_t            out_item_reg, out_item_next;

    logic [KEY_BITS-1:0]            key_mem [DEPTH];
    logic [COUNT_BITS-1:0]          count_mem [DEPTH];

    logic                  out_free, a_live, list_hold, advance, rd_en;
    logic                  emit;
    ksct_pkg::rsp_item_t   emit_item;
    logic                  key_wr, cnt_wr;
    logic [IDX_W-1:0]      wr_idx;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic [SUM_W-1:0]      qty_ext, cnt_ext, sum, diff;

    function automatic ksct_pkg::rsp_item_t slot_rsp(
        input logic [ksct_pkg::STATUS_W-1:0] st,
        input logic [ksct_pkg::AISLE_W-1:0]  ai,
        input logic [ksct_pkg::SHELF_W-1:0]  sh,
        input logic [KEY_BITS-1:0]           k,
        input logic [COUNT_BITS-1:0]         c,
        input logic                          lst
    );
        ksct_pkg::rsp_item_t r;
        r.status      = st;
        r.aisle       = ai;
        r.shelf       = sh;
        r.entry_key   = ksct_pkg::KEY_FIELD_W'(k);
        r.entry_count = ksct_pkg::COUNT_FIELD_W'(c);
        r.last        = lst;
        return r;
    endfunction

    function automatic ksct_pkg::rsp_item_t bare_rsp(
        input logic [ksct_pkg::STATUS_W-1:0] st
    );
        ksct_pkg::rsp_item_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign a_live    = (a_idx_reg < (IDX_W+1)'(DEPTH));
    assign list_hold = (op_reg == ksct_pkg::OP_LIST) && b_valid_reg && b_occ_reg
                       && pend_reg && !out_free;
    assign advance   = (state_reg == S_SCAN) && !list_hold;
    assign rd_en     = advance && a_live;
    assign pop       = (state_reg == S_IDLE) && head.valid;

    assign qty_ext = SUM_W'(qty_reg);
    assign cnt_ext = SUM_W'(m_count_reg);
    assign sum     = cnt_ext + qty_ext;
    assign diff    = cnt_ext - qty_ext;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        qty_next     = qty_reg;
        a_idx_next   = a_idx_reg;
        a_aisle_next = a_aisle_reg;
        a_shelf_next = a_shelf_reg;
        b_valid_next = b_valid_reg;
        b_occ_next   = b_occ_reg;
        b_idx_next   = b_idx_reg;
        b_aisle_next = b_aisle_reg;
        b_shelf_next = b_shelf_reg;
        match_next   = match_reg;
        m_idx_next   = m_idx_reg;
        m_aisle_next = m_aisle_reg;
        m_shelf_next = m_shelf_reg;
        m_count_next = m_count_reg;
        free_next    = free_reg;
        f_idx_next   = f_idx_reg;
        f_aisle_next = f_aisle_reg;
        f_shelf_next = f_shelf_reg;
        pend_next    = pend_reg;
        p_aisle_next = p_aisle_reg;
        p_shelf_next = p_shelf_reg;
        p_key_next   = p_key_reg;
        p_count_next = p_count_reg;
        occ_next     = occ_reg;
        emit         = 1'b0;
        emit_item    = '0;
        key_wr       = 1'b0;
        cnt_wr       = 1'b0;
        wr_idx       = m_idx_reg;
        cnt_wr_data  = sum[COUNT_BITS-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    op_next      = head.entry.op;
                    key_next     = KEY_BITS'(head.entry.key);
                    qty_next     = head.entry.qty;
                    a_idx_next   = '0;
                    a_aisle_next = '0;
                    a_shelf_next = '0;
                    b_valid_next = 1'b0;
                    match_next   = 1'b0;
                    free_next    = 1'b0;
                    pend_next    = 1'b0;
                    if (head.entry.op == ksct_pkg::OP_STOCK
                        || head.entry.op == ksct_pkg::OP_WITHDRAW
                        || head.entry.op == ksct_pkg::OP_LIST)
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            end

            S_SCAN:
            begin
                if (advance)
                begin
                    if (a_live)
                    begin
                        b_valid_next = 1'b1;
                        b_occ_next   = occ_reg[a_idx_reg[IDX_W-1:0]];
                        b_idx_next   = a_idx_reg[IDX_W-1:0];
                        b_aisle_next = a_aisle_reg;
                        b_shelf_next = a_shelf_reg;
                        a_idx_next   = a_idx_reg + 1'b1;
                        if (a_shelf_reg == SHELF_LAST)
                        begin
                            a_shelf_next = '0;
                            a_aisle_next = a_aisle_reg + 1'b1;
                        end
                        else
                            a_shelf_next = a_shelf_reg + 1'b1;
                    end
                    else
                        b_valid_next = 1'b0;

                    if (b_valid_reg)
                    begin
                        if (op_reg == ksct_pkg::OP_LIST)
                        begin
                            if (b_occ_reg)
                            begin
                                if (pend_reg)
                                begin
                                    emit      = 1'b1;
                                    emit_item = slot_rsp(ksct_pkg::ST_OK, p_aisle_reg,
                                                         p_shelf_reg, p_key_reg,
                                                         p_count_reg, 1'b0);
                                end
                                pend_next    = 1'b1;
                                p_aisle_next = b_aisle_reg;
                                p_shelf_next = b_shelf_reg;
                                p_key_next   = rd_key_reg;
                                p_count_next = rd_count_reg;
                            end
                        end
                        else
                        begin
                            if (b_occ_reg && rd_key_reg == key_reg && !match_reg)
                            begin
                                match_next   = 1'b1;
                                m_idx_next   = b_idx_reg;
                                m_aisle_next = b_aisle_reg;
                                m_shelf_next = b_shelf_reg;
                                m_count_next = rd_count_reg;
                            end
                            if (!b_occ_reg && !free_reg)
                            begin
                                free_next    = 1'b1;
                                f_idx_next   = b_idx_reg;
                                f_aisle_next = b_aisle_reg;
                                f_shelf_next = b_shelf_reg;
                            end
                        end
                    end
                    else if (!a_live)
                        state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        ksct_pkg::OP_BADQ:
                            emit_item = bare_rsp(ksct_pkg::ST_BADQ);
                        ksct_pkg::OP_NOKEY:
                            emit_item = bare_rsp(ksct_pkg::ST_NOTFOUND);
                        ksct_pkg::OP_LIST:
                        begin
                            if (pend_reg)
                                emit_item = slot_rsp(ksct_pkg::ST_OK, p_aisle_reg,
                                                     p_shelf_reg, p_key_reg,
                                                     p_count_reg, 1'b1);
                            else
                                emit_item = bare_rsp(ksct_pkg::ST_NONE);
                        end
                        ksct_pkg::OP_STOCK:
                        begin
                            priority if (match_reg && sum > CMAX)
                                emit_item = slot_rsp(ksct_pkg::ST_OVER, m_aisle_reg,
                                                     m_shelf_reg, key_reg, m_count_reg, 1'b1);
                            else if (match_reg)
                            begin
                                cnt_wr    = 1'b1;
                                emit_item = slot_rsp(ksct_pkg::ST_OK, m_aisle_reg,
                                                     m_shelf_reg, key_reg,
                                                     sum[COUNT_BITS-1:0], 1'b1);
                            end
                            else if (!free_reg)
                                emit_item = bare_rsp(ksct_pkg::ST_FULL);
                            else if (qty_ext > CMAX)
                                emit_item = bare_rsp(ksct_pkg::ST_OVER);
                            else
                            begin
                                // claim the first empty slot
                                key_wr      = 1'b1;
                                cnt_wr      = 1'b1;
                                wr_idx      = f_idx_reg;
                                cnt_wr_data = qty_ext[COUNT_BITS-1:0];
                                occ_next[f_idx_reg] = 1'b1;
                                emit_item = slot_rsp(ksct_pkg::ST_OK, f_aisle_reg,
                                                     f_shelf_reg, key_reg,
                                                     qty_ext[COUNT_BITS-1:0], 1'b1);
                            end
                        end
                        ksct_pkg::OP_WITHDRAW:
                        begin
                            priority if (!match_reg)
                                emit_item = bare_rsp(ksct_pkg::ST_NOTFOUND);
                            else if (m_count_reg == '0)
                                emit_item = slot_rsp(ksct_pkg::ST_EMPTY, m_aisle_reg,
                                                     m_shelf_reg, key_reg, m_count_reg, 1'b1);
                            else if (qty_reg == '0)
                                emit_item = slot_rsp(ksct_pkg::ST_BADQ, m_aisle_reg,
                                                     m_shelf_reg, key_reg, m_count_reg, 1'b1);
                            else if (qty_ext > cnt_ext)
                                emit_item = slot_rsp(ksct_pkg::ST_INSUFF, m_aisle_reg,
                                                     m_shelf_reg, key_reg, m_count_reg, 1'b1);
                            else
                            begin
                                cnt_wr      = 1'b1;
                                cnt_wr_data = diff[COUNT_BITS-1:0];
                                emit_item = slot_rsp(ksct_pkg::ST_OK, m_aisle_reg,
                                                     m_shelf_reg, key_reg,
                                                     diff[COUNT_BITS-1:0], 1'b1);
                            end
                        end
                        default:
                            emit = 1'b0;
                    endcase
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = emit_item;
        end
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            b_valid_reg   <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            a_idx_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= b_valid_next;
            match_reg     <= match_next;
            free_reg      <= free_next;
            pend_reg      <= pend_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            a_idx_reg     <= a_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        qty_reg      <= qty_next;
        a_aisle_reg  <= a_aisle_next;
        a_shelf_reg  <= a_shelf_next;
        b_occ_reg    <= b_occ_next;
        b_idx_reg    <= b_idx_next;
        b_aisle_reg  <= b_aisle_next;
        b_shelf_reg  <= b_shelf_next;
        m_idx_reg    <= m_idx_next;
        m_aisle_reg  <= m_aisle_next;
        m_shelf_reg  <= m_shelf_next;
        m_count_reg  <= m_count_next;
        f_idx_reg    <= f_idx_next;
        f_aisle_reg  <= f_aisle_next;
        f_shelf_reg  <= f_shelf_next;
        p_aisle_reg  <= p_aisle_next;
        p_shelf_reg  <= p_shelf_next;
        p_key_reg    <= p_key_next;
        p_count_reg  <= p_count_next;
        out_item_reg <= out_item_next;
    end

    // slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (key_wr)
            key_mem[wr_idx] <= key_reg;
        if (cnt_wr)
            count_mem[wr_idx] <= cnt_wr_data;
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[a_idx_reg[IDX_W-1:0]];
            rd_count_reg <= count_mem[a_idx_reg[IDX_W-1:0]];
        end
    end

endmodule

### sv/keyed_stock_count_table.sv
// Top level of the keyed stock count table.
// Depends on ksct_pkg, ksct_front, ksct_cmd_fifo and ksct_back.
//
//   cmd channel (cmd_valid / cmd_stall / cmd) carries request items: stock,
//   withdraw or list. rsp channel (rsp_valid / rsp_stall / rsp) carries
//   result items. An item moves at a rising edge with valid high, stall low.
//   Stock and withdraw give one result item; list gives one per occupied
//   slot in aisle-major order, last set on the final one, or a single
//   no-entries item. Unused mode codes are taken and give nothing.
//   Items are worked one at a time. Stock, withdraw and list walk the whole
//   slot store, one slot a cycle through the single read port, unless a
//   stalled receiver pauses a list walk. Bad-quantity stock items and
//   zero-key items skip the walk. A two-entry queue takes up to two
//   further items meanwhile; cmd_stall rises when it is full. A stalled
//   receiver holds the result register, pauses a list walk and holds other
//   items at the end of their walk; nothing is dropped.
//   Reset empties the table at once through per-slot occupied flags, so
//   items are taken right after reset.
module keyed_stock_count_table #(
    parameter int AISLES            = 4,
    parameter int SHELVES_PER_AISLE = 16,
    parameter int KEY_BITS          = 64,
    parameter int COUNT_BITS        = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ksct_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ksct_pkg::rsp_item_t rsp
);

    logic                   queue_full;
    logic                   push;
    logic                   pop;
    ksct_pkg::queue_entry_t push_entry;
    ksct_pkg::queue_head_t  head;

    // front: mask the key, sort the item into an operation
    ksct_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_stall  (cmd_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // short queue so the front keeps taking items while the walk runs
    ksct_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    // back: slot walk, table update and result register
    ksct_back #(
        .AISLES            (AISLES),
        .SHELVES_PER_AISLE (SHELVES_PER_AISLE),
        .KEY_BITS          (KEY_BITS),
        .COUNT_BITS        (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
